[design/fpl_pkg.sv]
package fpl_pkg;

  // Number of coefficients held in the tap ROM; taps beyond it are zero.
  localparam int ROM_TAPS = 64;

  // Symmetric low-pass taps, Q1.15, rounded to nearest.
  localparam logic signed [15:0] COEF_ROM [ROM_TAPS] = '{
    -16'sd19,   -16'sd20,   16'sd22,    16'sd26,    -16'sd31,   -16'sd38,   16'sd46,    16'sd57,
    -16'sd69,   -16'sd83,   16'sd100,   16'sd119,   -16'sd141,  -16'sd166,  16'sd194,   16'sd226,
    -16'sd263,  -16'sd304,  16'sd351,   16'sd406,   -16'sd468,  -16'sd541,  16'sd628,   16'sd733,
    -16'sd864,  -16'sd1030, 16'sd1252,  16'sd1566,  -16'sd2051, -16'sd2911, 16'sd4897,  16'sd14759,
    16'sd14759, 16'sd4897,  -16'sd2911, -16'sd2051, 16'sd1566,  16'sd1252,  -16'sd1030, -16'sd864,
    16'sd733,   16'sd628,   -16'sd541,  -16'sd468,  16'sd406,   16'sd351,   -16'sd304,  -16'sd263,
    16'sd226,   16'sd194,   -16'sd166,  -16'sd141,  16'sd119,   16'sd100,   -16'sd83,   -16'sd69,
    16'sd57,    16'sd46,    -16'sd38,   -16'sd31,   16'sd26,    16'sd22,    -16'sd20,   -16'sd19
  };

  localparam int SAMPLE_W = 12;
  localparam int FILT_W   = 14;
  localparam int PCM_W    = 16;

  localparam int ADC_MID  = 2048;
  localparam int PCM_GAIN = 16;
  localparam int FILT_MIN = -8192;
  localparam int FILT_MAX = 8191;
  localparam int PCM_MIN  = -32768;
  localparam int PCM_MAX  = 32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } fpl_state_t;

endpackage

[design/fir_lowpass_to_pcm_unit.sv]
// An accepted sample beat passes the tap loop (ST_RUN), the pipeline drain (ST_DRAIN), rounding
// (ST_ROUND) and hand-off (ST_EMIT) to the result channel; a new sample is taken only back in
// ST_IDLE. A single shared multiply-accumulate steps once per tap via the delay-line read port.
// Reset (rst_n low, synchronous) clears the control state, write pointer and fill count;
// delay-line entries not yet written since reset read as zero through the fill count.
module fir_lowpass_to_pcm_unit #(
  parameter int TAPS      = 64,
  parameter int COEF_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [fpl_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpl_pkg::FILT_W-1:0]   out_filt_code,
  output logic signed [fpl_pkg::PCM_W-1:0]    out_pcm_code
);

  // Address width of the delay line, and width of the fill count, which must
  // be able to hold TAPS itself.
  localparam int AW  = $clog2(TAPS);
  localparam int FW  = $clog2(TAPS + 1);
  // Product of a zero-extended 12-bit sample and a signed coefficient.
  localparam int PW  = COEF_BITS + fpl_pkg::SAMPLE_W + 1;
  // The accumulator has room for the sum of TAPS products.
  localparam int ACW = PW + $clog2(TAPS);
  // Coefficient rescaling from the Q1.15 ROM words.
  localparam int UP  = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
  localparam int DN  = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
  localparam int FRAC = COEF_BITS - 1;

  localparam logic [AW-1:0]          LAST_ADDR = AW'(TAPS - 1);
  localparam logic [FW-1:0]          FILL_FULL = FW'(TAPS);
  localparam logic signed [ACW-1:0]  TRUNC_BIAS = ACW'((64'sd1 <<< FRAC) - 64'sd1);
  localparam logic signed [ACW-1:0]  Q_MIN = ACW'(fpl_pkg::FILT_MIN);
  localparam logic signed [ACW-1:0]  Q_MAX = ACW'(fpl_pkg::FILT_MAX);
  localparam logic signed [19:0]     P_MIN = 20'(fpl_pkg::PCM_MIN);
  localparam logic signed [19:0]     P_MAX = 20'(fpl_pkg::PCM_MAX);
  localparam logic signed [19:0]     MID   = 20'(fpl_pkg::ADC_MID);
  localparam logic signed [19:0]     GAIN  = 20'(fpl_pkg::PCM_GAIN);

  // Tap coefficient for a given tap number. Narrower coefficients are rounded
  // to nearest with halves going up (add half, then floor by arithmetic shift);
  // wider ones gain zero fraction bits. Taps past the ROM are zero.
  function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [AW-1:0] tap);
    logic signed [31:0] v;
    logic signed [31:0] t;
    logic signed [31:0] r;
    v = '0;
    t = '0;
    r = '0;
    if (32'(tap) < fpl_pkg::ROM_TAPS) begin
      v = 32'(fpl_pkg::COEF_ROM[6'(tap)]);
      if (COEF_BITS >= 16) begin
        r = v <<< UP;
      end else begin
        t = v + (32'sd1 <<< (DN - 1));
        r = t >>> DN;
      end
    end
    return COEF_BITS'(r);
  endfunction

  fpl_pkg::fpl_state_t state_r, state_nxt;

  // Delay line: a single-port-style memory, one write on acceptance, one read
  // per tap while the sum runs. The two never fall in the same cycle, since a
  // new sample is only taken once the previous sum has left the pipeline.
  logic [fpl_pkg::SAMPLE_W-1:0] mem [TAPS];
  logic [fpl_pkg::SAMPLE_W-1:0] rd_data_r;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] tap_r, tap_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  // Read stage bookkeeping travelling alongside the memory read data.
  logic          s1_valid_r;
  logic          s1_live_r;
  logic [AW-1:0] s1_tap_r;

  logic                   p_valid_r;
  logic signed [PW-1:0]   p_r, p_nxt;
  logic signed [ACW-1:0]  acc_r, acc_nxt;

  logic signed [ACW-1:0]  biased;
  logic signed [ACW-1:0]  quot;
  logic signed [fpl_pkg::FILT_W-1:0] filt_r, filt_nxt;
  logic signed [19:0]     pcm_wide;
  logic signed [fpl_pkg::PCM_W-1:0]  pcm_nxt;

  logic signed [COEF_BITS-1:0] coef;

  logic out_valid_r;
  logic signed [fpl_pkg::FILT_W-1:0] out_filt_r;
  logic signed [fpl_pkg::PCM_W-1:0]  out_pcm_r;

  logic accept;
  logic issue;
  logic emit;
  logic last_tap;
  logic pipe_empty;

  // Control outputs of the sequencer. A new result waits in ST_EMIT while the
  // output register holds a stalled result, and no new sample is taken meanwhile.
  always_comb begin
    in_stall = (state_r != fpl_pkg::ST_IDLE);
    issue    = (state_r == fpl_pkg::ST_RUN);
    emit     = (state_r == fpl_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  end

  assign accept     = in_valid && !in_stall;
  assign last_tap   = (tap_r == LAST_ADDR);
  assign pipe_empty = !s1_valid_r && !p_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = fpl_pkg::ST_RUN;
        end
      end
      fpl_pkg::ST_RUN: begin
        if (last_tap) begin
          state_nxt = fpl_pkg::ST_DRAIN;
        end
      end
      fpl_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = fpl_pkg::ST_ROUND;
        end
      end
      fpl_pkg::ST_ROUND: begin
        state_nxt = fpl_pkg::ST_EMIT;
      end
      fpl_pkg::ST_EMIT: begin
        if (emit) begin
          state_nxt = fpl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpl_pkg::ST_IDLE;
      end
    endcase
  end

  // Pointers. The write pointer wraps modulo TAPS; the read pointer starts at
  // the newest sample and walks backwards towards the oldest.
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    tap_nxt  = tap_r;
    fill_nxt = fill_r;
    if (accept) begin
      wp_nxt   = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      rp_nxt   = wp_r;
      tap_nxt  = '0;
      fill_nxt = (fill_r == FILL_FULL) ? fill_r : fill_r + 1'b1;
    end else if (issue) begin
      rp_nxt  = (rp_r == '0) ? LAST_ADDR : rp_r - 1'b1;
      tap_nxt = tap_r + 1'b1;
    end
  end

  // Multiply stage. An entry beyond the fill count has never been written
  // since reset and stands for zero.
  assign coef = coef_at(s1_tap_r);

  always_comb begin
    p_nxt = '0;
    if (s1_live_r) begin
      p_nxt = $signed({1'b0, rd_data_r}) * coef;
    end
  end

  // Accumulate stage.
  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = '0;
    end else if (p_valid_r) begin
      acc_nxt = acc_r + ACW'(p_r);
    end
  end

  // Scale down by the coefficient fraction, truncating towards zero, then
  // saturate to the 14-bit filtered range.
  always_comb begin
    biased = acc_r + (acc_r[ACW-1] ? TRUNC_BIAS : '0);
    quot   = biased >>> FRAC;
    if (quot < Q_MIN) begin
      filt_nxt = fpl_pkg::FILT_W'(fpl_pkg::FILT_MIN);
    end else if (quot > Q_MAX) begin
      filt_nxt = fpl_pkg::FILT_W'(fpl_pkg::FILT_MAX);
    end else begin
      filt_nxt = fpl_pkg::FILT_W'(quot);
    end
  end

  // PCM conversion: remove the converter mid-point, apply the gain, saturate.
  always_comb begin
    pcm_wide = (20'(filt_r) - MID) * GAIN;
    if (pcm_wide < P_MIN) begin
      pcm_nxt = fpl_pkg::PCM_W'(fpl_pkg::PCM_MIN);
    end else if (pcm_wide > P_MAX) begin
      pcm_nxt = fpl_pkg::PCM_W'(fpl_pkg::PCM_MAX);
    end else begin
      pcm_nxt = fpl_pkg::PCM_W'(pcm_wide);
    end
  end

  // Delay-line memory: write on acceptance, registered read while running.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp_r] <= in_adc_sample;
    end
    if (issue) begin
      rd_data_r <= mem[rp_r];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpl_pkg::ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      s1_valid_r <= issue;
      p_valid_r  <= s1_valid_r;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rp_r  <= rp_nxt;
    tap_r <= tap_nxt;
    acc_r <= acc_nxt;
    if (issue) begin
      s1_tap_r  <= tap_r;
      s1_live_r <= (FW'(rp_r) < fill_r);
    end
    if (s1_valid_r) begin
      p_r <= p_nxt;
    end
    if (state_r == fpl_pkg::ST_ROUND) begin
      filt_r <= filt_nxt;
    end
    if (emit) begin
      out_filt_r <= filt_r;
      out_pcm_r  <= pcm_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filt_code = out_filt_r;
  assign out_pcm_code  = out_pcm_r;

endmodule
